// ===== design/btt_pkg.sv =====
package btt_pkg;

  localparam int NODE_COUNT  = 64;
  localparam int VALUE_BITS  = 32;
  localparam int MAX_RESULTS = 64;
  localparam int NB = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);
  localparam int MARK_BIT = 6;

  localparam logic [1:0] ORD_IN   = 2'd0;
  localparam logic [1:0] ORD_PRE  = 2'd1;
  localparam logic [1:0] ORD_POST = 2'd2;
  localparam logic [1:0] ORD_BFS  = 2'd3;

  localparam logic CFG_ROOT  = 1'b0;
  localparam logic CFG_ORDER = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  typedef struct packed {
    logic [6:0]            left;
    logic [6:0]            right;
    logic [VALUE_BITS-1:0] value;
  } node_t;

  typedef struct packed {
    logic          valid;
    logic [NB-1:0] idx;
  } nsel_t;

  typedef struct packed {
    logic [5:0]  visited_node;
    logic [31:0] element_value;
    logic        last;
    logic        tree_empty;
  } res_t;

  // -1 and anything outside the table mean no node
  function automatic nsel_t norm_node(input logic [6:0] v);
    nsel_t r;
    r.valid = !v[6] && ({1'b0, v[5:0]} < 7'(NODE_COUNT));
    r.idx   = v[NB-1:0];
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] store_value(input logic [31:0] d);
    logic [VALUE_BITS-1:0] v;
    for (int i = 0; i < VALUE_BITS; i++) begin
      v[i] = (i < 32) ? d[i] : 1'b0;
    end
    return v;
  endfunction

  function automatic logic [31:0] ext_value(input logic [VALUE_BITS-1:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = (i < VALUE_BITS) ? v[i] : v[VALUE_BITS-1];
    end
    return r;
  endfunction

endpackage

// ===== design/btt_in_if.sv =====
interface btt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  node_index;
  logic [6:0]  left_child;
  logic [6:0]  right_child;
  logic [31:0] node_data;

  modport source (output valid, func, node_index, left_child, right_child, node_data,
                  input ready);
  modport sink (input valid, func, node_index, left_child, right_child, node_data,
                output ready);
endinterface

// ===== design/btt_out_if.sv =====
interface btt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  visited_node;
  logic [31:0] element_value;
  logic        last;
  logic        tree_empty;

  modport source (output valid, visited_node, element_value, last, tree_empty,
                  input ready);
  modport sink (input valid, visited_node, element_value, last, tree_empty,
                output ready);
endinterface

// ===== design/binary_tree_traversal_engine.sv =====
// Binary tree walker over a 64-node table. A write word (func 0) stores one node. A run
// word (func 1) walks the tree from root_node in walk_order and returns one word per
// visited node, the final one flagged last; an empty root gives a single word with
// tree_empty set. The node table and the walk stack/queue are two synchronous RAMs with
// registered reads. Preorder and breadth-first handle each node in steps: stack read,
// node read, emit and first push, second push. Inorder pushes each node of the left
// descent and reads it, then pops, reads and emits each node, and ends each descent
// with a check. Postorder pops every node twice. No new word is taken while a run is
// in progress.
module binary_tree_traversal_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  btt_in_if.sink     in_i,
  btt_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DESC, S_DESC_W, S_POP, S_POP_W, S_PO_W, S_EMIT_W, S_PUSH2, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic [6:0] root_q, root_d;
  logic [1:0] order_q, order_d;
  logic [btt_pkg::CW-1:0] head_q, head_d, tail_q, tail_d, tail_m1;
  logic [btt_pkg::RW-1:0] cnt_q, cnt_d;
  btt_pkg::nsel_t cur_q, cur_d, first, second, r;
  logic [btt_pkg::NB-1:0] n_q, n_d;
  logic pend_valid_q, pend_valid_d, out_valid_q, out_valid_d;
  btt_pkg::res_t pend_q, pend_d, out_q, out_d;

  btt_pkg::node_t node_mem [btt_pkg::NODE_COUNT];
  btt_pkg::node_t node_rd_q, node_wdata;
  logic node_we, node_re;
  logic [btt_pkg::NB-1:0] node_waddr, node_raddr;

  logic [7:0] st_mem [btt_pkg::NODE_COUNT];
  logic [7:0] st_rd_q, st_wdata;
  logic st_we, st_re;
  logic [btt_pkg::NB-1:0] st_waddr, st_raddr;

  logic full, out_free, more;

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.visited_node  = out_q.visited_node;
  assign out_o.element_value = out_q.element_value;
  assign out_o.last          = out_q.last;
  assign out_o.tree_empty    = out_q.tree_empty;

  assign full     = tail_q >= btt_pkg::CW'(btt_pkg::NODE_COUNT);
  assign out_free = !out_valid_q || out_o.ready;
  assign tail_m1  = tail_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rd_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_rd_q <= st_mem[st_raddr];
  end

  always_comb begin
    state_d      = state_q;
    root_d       = root_q;
    order_d      = order_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    node_we      = 1'b0;
    node_waddr   = in_i.node_index[btt_pkg::NB-1:0];
    node_wdata.left  = in_i.left_child;
    node_wdata.right = in_i.right_child;
    node_wdata.value = btt_pkg::store_value(in_i.node_data);
    node_re      = 1'b0;
    node_raddr   = cur_q.idx;
    st_we        = 1'b0;
    st_waddr     = tail_q[btt_pkg::NB-1:0];
    st_wdata     = {2'b00, 6'(cur_q.idx)};
    st_re        = 1'b0;
    st_raddr     = head_q[btt_pkg::NB-1:0];
    more         = 1'b0;
    first        = btt_pkg::norm_node(node_rd_q.right);
    second       = btt_pkg::norm_node(node_rd_q.left);
    r            = btt_pkg::norm_node(root_q);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btt_pkg::CFG_ROOT:  root_d  = cfg_data_i;
        btt_pkg::CFG_ORDER: order_d = cfg_data_i[1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.func == btt_pkg::FUNC_WRITE) begin
            node_we = ({1'b0, in_i.node_index} < 7'(btt_pkg::NODE_COUNT));
          end else begin
            head_d = '0;
            tail_d = '0;
            cnt_d  = '0;
            cur_d  = r;
            if (!r.valid) begin
              pend_valid_d = 1'b1;
              pend_d       = '{visited_node: 6'd0, element_value: 32'd0,
                               last: 1'b1, tree_empty: 1'b1};
              state_d      = S_FIN;
            end else if (order_q == btt_pkg::ORD_IN || order_q == btt_pkg::ORD_POST) begin
              state_d = S_DESC;
            end else begin
              st_we    = 1'b1;
              st_waddr = '0;
              st_wdata = {2'b00, 6'(r.idx)};
              tail_d   = btt_pkg::CW'(1);
              state_d  = S_POP;
            end
          end
        end
      end
      S_DESC: begin
        if (cur_q.valid && !full) begin
          st_we   = 1'b1;
          tail_d  = tail_q + 1'b1;
          node_re = 1'b1;
          state_d = S_DESC_W;
        end else begin
          state_d = S_POP;
        end
      end
      S_DESC_W: begin
        cur_d   = btt_pkg::norm_node(node_rd_q.left);
        state_d = S_DESC;
      end
      S_POP: begin
        more = (order_q == btt_pkg::ORD_BFS) ? (head_q < tail_q) : (tail_q != '0);
        if (more && cnt_q < btt_pkg::RW'(btt_pkg::MAX_RESULTS)) begin
          st_re = 1'b1;
          if (order_q == btt_pkg::ORD_BFS) begin
            head_d = head_q + 1'b1;
          end else begin
            st_raddr = tail_m1[btt_pkg::NB-1:0];
            tail_d   = tail_m1;
          end
          state_d = S_POP_W;
        end else begin
          state_d = S_FIN;
        end
      end
      S_POP_W: begin
        n_d        = st_rd_q[btt_pkg::NB-1:0];
        node_re    = 1'b1;
        node_raddr = st_rd_q[btt_pkg::NB-1:0];
        if (order_q == btt_pkg::ORD_POST && !st_rd_q[btt_pkg::MARK_BIT]) begin
          // revisit after the right subtree; a slot was just freed by the pop
          st_we    = 1'b1;
          st_wdata = st_rd_q | (8'd1 << btt_pkg::MARK_BIT);
          tail_d   = tail_q + 1'b1;
          state_d  = S_PO_W;
        end else begin
          state_d = S_EMIT_W;
        end
      end
      S_PO_W: begin
        cur_d   = btt_pkg::norm_node(node_rd_q.right);
        state_d = S_DESC;
      end
      S_EMIT_W: begin
        // one result held back so the final one can be flagged
        if (out_free || !pend_valid_q) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_valid_d = 1'b1;
          pend_d       = '{visited_node: 6'(n_q),
                           element_value: btt_pkg::ext_value(node_rd_q.value),
                           last: 1'b0, tree_empty: 1'b0};
          cnt_d        = cnt_q + 1'b1;
          case (order_q)
            btt_pkg::ORD_IN: begin
              cur_d   = btt_pkg::norm_node(node_rd_q.right);
              state_d = S_DESC;
            end
            btt_pkg::ORD_POST: state_d = S_POP;
            default: begin
              if (order_q == btt_pkg::ORD_BFS) begin
                first  = btt_pkg::norm_node(node_rd_q.left);
                second = btt_pkg::norm_node(node_rd_q.right);
              end
              if (first.valid && !full) begin
                st_we    = 1'b1;
                st_wdata = {2'b00, 6'(first.idx)};
                tail_d   = tail_q + 1'b1;
              end
              cur_d   = second;
              state_d = S_PUSH2;
            end
          endcase
        end
      end
      S_PUSH2: begin
        if (cur_q.valid && !full) begin
          st_we  = 1'b1;
          tail_d = tail_q + 1'b1;
        end
        state_d = S_POP;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      root_q       <= 7'h7F;
      order_q      <= btt_pkg::ORD_IN;
      head_q       <= '0;
      tail_q       <= '0;
      cnt_q        <= '0;
      cur_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      root_q       <= root_d;
      order_q      <= order_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      cnt_q        <= cnt_d;
      cur_q        <= cur_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule
